[rtl/sbed_pkg.sv]
// Shared types and constants of the shifter button event detector.
`timescale 1ns / 1ps
`default_nettype none

package sbed_pkg;

  localparam int unsigned NumButtons = 5;
  localparam int unsigned CfgWidth   = 12;
  localparam int unsigned CfgIdxWidth = 3;

  // Button positions, in examination order
  localparam int unsigned BtnRearOne  = 0;
  localparam int unsigned BtnRearTwo  = 1;
  localparam int unsigned BtnFrontOne = 2;
  localparam int unsigned BtnFrontTwo = 3;
  localparam int unsigned BtnMode     = 4;

  // Register indexes
  localparam logic [CfgIdxWidth-1:0] CfgPrescaleLimit = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgCountCap      = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgShortMark     = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgLongMark      = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgReleaseLow    = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgReleaseMid    = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CfgComboLimit    = 3'd6;

  // Register reset values
  localparam logic [7:0]  RstPrescaleLimit = 8'd30;
  localparam logic [11:0] RstCountCap      = 12'd3000;
  localparam logic [11:0] RstShortMark     = 12'd100;
  localparam logic [11:0] RstLongMark      = 12'd2000;
  localparam logic [11:0] RstReleaseLow    = 12'd50;
  localparam logic [11:0] RstReleaseMid    = 12'd1500;
  localparam logic [7:0]  RstComboLimit    = 8'd200;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_LONG_R1    = 4'd1,
    EV_LONG_R2    = 4'd2,
    EV_LONG_F1    = 4'd3,
    EV_LONG_F2    = 4'd4,
    EV_SHORT_PAIR = 4'd5,
    EV_SHORT_R2   = 4'd6,
    EV_SHORT_F1   = 4'd7,
    EV_REL_R1     = 4'd8,
    EV_REL_R2     = 4'd9,
    EV_REL_F1     = 4'd10,
    EV_MODE_ON    = 4'd11,
    EV_MODE_OFF   = 4'd12
  } event_e;

  typedef struct packed {
    logic [7:0]  prescale_limit;
    logic [11:0] count_cap;
    logic [11:0] short_mark;
    logic [11:0] long_mark;
    logic [11:0] release_low;
    logic [11:0] release_mid;
    logic [7:0]  combo_limit;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/sbed_cfg.sv]
// Configuration register bank of the shifter button event detector.
`timescale 1ns / 1ps
`default_nettype none

module sbed_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [sbed_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  wire logic [sbed_pkg::CfgWidth-1:0]       cfg_wdata_i,
  output sbed_pkg::cfg_t                           cfg_o
);

  sbed_pkg::cfg_t cfg_q;

  // Drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prescale_limit <= sbed_pkg::RstPrescaleLimit;
      cfg_q.count_cap      <= sbed_pkg::RstCountCap;
      cfg_q.short_mark     <= sbed_pkg::RstShortMark;
      cfg_q.long_mark      <= sbed_pkg::RstLongMark;
      cfg_q.release_low    <= sbed_pkg::RstReleaseLow;
      cfg_q.release_mid    <= sbed_pkg::RstReleaseMid;
      cfg_q.combo_limit    <= sbed_pkg::RstComboLimit;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sbed_pkg::CfgPrescaleLimit: cfg_q.prescale_limit <= cfg_wdata_i[7:0];
        sbed_pkg::CfgCountCap:      cfg_q.count_cap      <= cfg_wdata_i;
        sbed_pkg::CfgShortMark:     cfg_q.short_mark     <= cfg_wdata_i;
        sbed_pkg::CfgLongMark:      cfg_q.long_mark      <= cfg_wdata_i;
        sbed_pkg::CfgReleaseLow:    cfg_q.release_low    <= cfg_wdata_i;
        sbed_pkg::CfgReleaseMid:    cfg_q.release_mid    <= cfg_wdata_i;
        sbed_pkg::CfgComboLimit:    cfg_q.combo_limit    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/sbed_step.sv]
// Next-state and event logic for one tick of the button event detector.
`timescale 1ns / 1ps
`default_nettype none

module sbed_step #(
  parameter int unsigned COUNT_WIDTH = 12
) (
  input  wire logic [sbed_pkg::NumButtons-1:0]                  btn_i,
  input  wire sbed_pkg::cfg_t                                   cfg_i,
  input  wire logic [sbed_pkg::NumButtons-1:0][7:0]             pre_i,
  input  wire logic [sbed_pkg::NumButtons-1:0][COUNT_WIDTH-1:0] hold_i,
  input  wire logic [7:0]                                       combo_i,
  output logic      [sbed_pkg::NumButtons-1:0][7:0]             pre_o,
  output logic      [sbed_pkg::NumButtons-1:0][COUNT_WIDTH-1:0] hold_o,
  output logic      [7:0]                                       combo_o,
  output sbed_pkg::event_e                                      event_o,
  output logic                                                  activity_o
);

  localparam int unsigned CmpW = (COUNT_WIDTH > sbed_pkg::CfgWidth) ?
                                 COUNT_WIDTH : sbed_pkg::CfgWidth;
  localparam int unsigned R1 = sbed_pkg::BtnRearOne;
  localparam int unsigned R2 = sbed_pkg::BtnRearTwo;
  localparam int unsigned F1 = sbed_pkg::BtnFrontOne;
  localparam int unsigned F2 = sbed_pkg::BtnFrontTwo;
  localparam int unsigned MD = sbed_pkg::BtnMode;

  function automatic logic [CmpW-1:0] ext_h(input logic [COUNT_WIDTH-1:0] x);
    return CmpW'(x);
  endfunction

  function automatic logic [CmpW-1:0] ext_c(input logic [sbed_pkg::CfgWidth-1:0] x);
    return CmpW'(x);
  endfunction

  logic [CmpW-1:0] cap_x, short_x, long_x, low_x, mid_x;
  assign cap_x   = ext_c(cfg_i.count_cap);
  assign short_x = ext_c(cfg_i.short_mark);
  assign long_x  = ext_c(cfg_i.long_mark);
  assign low_x   = ext_c(cfg_i.release_low);
  assign mid_x   = ext_c(cfg_i.release_mid);

  // Advance result of each button from the stored state; no button's own
  // counters are touched before that button is examined.
  logic [sbed_pkg::NumButtons-1:0][7:0]             adv_pre;
  logic [sbed_pkg::NumButtons-1:0][COUNT_WIDTH-1:0] adv_hold;
  logic [sbed_pkg::NumButtons-1:0]                  adv_step;

  for (genvar b = 0; b < sbed_pkg::NumButtons; b++) begin : g_adv
    always_comb begin
      adv_hold[b] = hold_i[b];
      if (pre_i[b] < cfg_i.prescale_limit) begin
        adv_pre[b]  = pre_i[b] + 8'd1;
        adv_step[b] = 1'b0;
      end else begin
        adv_pre[b]  = '0;
        adv_step[b] = 1'b1;
        if ((ext_h(hold_i[b]) < cap_x) && (hold_i[b] != {COUNT_WIDTH{1'b1}})) begin
          adv_hold[b] = hold_i[b] + COUNT_WIDTH'(1);
        end
      end
    end
  end

  logic [sbed_pkg::NumButtons-1:0][7:0]             p;
  logic [sbed_pkg::NumButtons-1:0][COUNT_WIDTH-1:0] h;
  logic [7:0]                                       cc;
  sbed_pkg::event_e                                 ev;
  logic                                             act;
  logic                                             done;
  logic                                             combo_idle;

  always_comb begin
    p          = pre_i;
    h          = hold_i;
    cc         = combo_i;
    ev         = sbed_pkg::EV_NONE;
    act        = 1'b0;
    done       = 1'b0;
    combo_idle = (combo_i == 8'd0);

    // rear one
    if (btn_i[R1]) begin
      act   = 1'b1;
      p[R1] = adv_pre[R1];
      h[R1] = adv_hold[R1];
      if (adv_step[R1] && ext_h(h[R1]) == long_x && ext_h(h[R2]) > mid_x && combo_idle) begin
        ev = sbed_pkg::EV_LONG_R1; done = 1'b1;
      end
    end else if (ext_h(h[R1]) > mid_x) begin
      h[R1] = '0;
      ev = sbed_pkg::EV_REL_R1; done = 1'b1;
    end else begin
      p[R1] = '0; h[R1] = '0;
    end

    // rear two
    if (!done) begin
      if (btn_i[R2]) begin
        act   = 1'b1;
        p[R2] = adv_pre[R2];
        h[R2] = adv_hold[R2];
        if (adv_step[R2] && combo_idle) begin
          if (ext_h(h[R2]) == short_x && h[R1] == '0) begin
            ev = sbed_pkg::EV_SHORT_R2; done = 1'b1;
          end else if (ext_h(h[R2]) == short_x && ext_h(h[R1]) > short_x) begin
            ev = sbed_pkg::EV_SHORT_PAIR; done = 1'b1;
          end else if (ext_h(h[R2]) == long_x && h[R1] == '0) begin
            ev = sbed_pkg::EV_LONG_R2; done = 1'b1;
          end
        end
      end else begin
        if (combo_idle) begin
          if (ext_h(h[R1]) > low_x && ext_h(h[R1]) < cap_x &&
              ext_h(h[R2]) > low_x && ext_h(h[R2]) < mid_x) begin
            h[R1] = '0; h[R2] = '0;
          end else if (ext_h(h[R2]) > low_x && ext_h(h[R2]) < mid_x) begin
            h[R2] = '0;
          end else if (ext_h(h[R2]) > long_x) begin
            h[R2] = '0;
            ev = sbed_pkg::EV_REL_R2; done = 1'b1;
          end
        end
        if (!done) begin
          p[R2] = '0; h[R2] = '0;
        end
      end
    end

    // front one
    if (!done) begin
      if (btn_i[F1]) begin
        act   = 1'b1;
        p[F1] = adv_pre[F1];
        h[F1] = adv_hold[F1];
        if (adv_step[F1] && ext_h(h[F1]) == short_x) begin
          ev = sbed_pkg::EV_SHORT_F1; done = 1'b1;
        end else if (adv_step[F1] && ext_h(h[F1]) == long_x) begin
          ev = sbed_pkg::EV_LONG_F1; done = 1'b1;
        end
      end else begin
        if (combo_idle) begin
          if (ext_h(h[F1]) > low_x && ext_h(h[F1]) < mid_x) begin
            h[F1] = '0;
          end else if (ext_h(h[F1]) > mid_x) begin
            h[F1] = '0;
            ev = sbed_pkg::EV_REL_F1; done = 1'b1;
          end
        end
        if (!done) begin
          p[F1] = '0; h[F1] = '0;
        end
      end
    end

    // front two
    if (!done) begin
      if (btn_i[F2]) begin
        act   = 1'b1;
        p[F2] = adv_pre[F2];
        h[F2] = adv_hold[F2];
        if (adv_step[F2] && ext_h(h[F2]) == long_x) begin
          ev = sbed_pkg::EV_LONG_F2; done = 1'b1;
        end
      end else begin
        p[F2] = '0; h[F2] = '0;
      end
    end

    // mode
    if (!done) begin
      if (btn_i[MD]) begin
        act   = 1'b1;
        p[MD] = adv_pre[MD];
        h[MD] = adv_hold[MD];
        if (adv_step[MD] && ext_h(h[MD]) == long_x) begin
          ev = sbed_pkg::EV_MODE_ON; done = 1'b1;
        end
      end else begin
        if (ext_h(h[MD]) > long_x) begin
          ev = sbed_pkg::EV_MODE_OFF; done = 1'b1;
        end
        p[MD] = '0; h[MD] = '0;
      end
    end

    // combo: rear two and front one held long together
    if (!done) begin
      if (ext_h(h[F1]) > mid_x && ext_h(h[R2]) > mid_x) begin
        if (cc < cfg_i.combo_limit) begin
          cc = cc + 8'd1;
        end else begin
          ev = sbed_pkg::EV_MODE_ON;
        end
      end else if (cc == cfg_i.combo_limit) begin
        cc = 8'd0;
        ev = sbed_pkg::EV_MODE_OFF;
      end
    end
  end

  assign pre_o      = p;
  assign hold_o     = h;
  assign combo_o    = cc;
  assign event_o    = ev;
  assign activity_o = act;

endmodule

`default_nettype wire

[rtl/shifter_button_event_detector_top.sv]
// Top level of the shifter button event detector: state, handshake, output word.
//
// Use: one input word per tick on the s_axis channel carries the five
// button levels (bit 0 rear one .. bit 4 mode, 1 = pressed). Each accepted
// word yields exactly one output word on the m_axis channel holding the
// event code (bits 3:0, zero for none) and the activity flag (bit 4),
// which tells the caller to restart its idle timer.
// Latency: the result word is valid the cycle after its input is accepted.
// Throughput: one word per clock cycle. The per-button counters and the
// combo counter update at the accepting edge, so the next tick sees them
// at once; the whole tick is one pass of compare and increment logic.
// Stall: the single output register holds its word while m_axis_tready_i
// is low; s_axis_tready_o stays high as long as that register is empty or
// being taken in the same cycle, so a stalled receiver stalls the sender
// after one word.
// Configuration: write registers through cfg_we_i / cfg_idx_i /
// cfg_wdata_i while no tick is in flight; unknown indexes are dropped.
// Reset: all counters clear, registers take their default values and the
// output register empties.
`timescale 1ns / 1ps
`default_nettype none

module shifter_button_event_detector_top #(
  parameter int unsigned COUNT_WIDTH = 12
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [sbed_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [sbed_pkg::CfgWidth-1:0]    cfg_wdata_i,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [0] rear_one_pressed, [1] rear_two_pressed, [2] front_one_pressed,
  // [3] front_two_pressed, [4] mode_pressed, [7:5] zero
  input  wire logic [7:0]                       s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [3:0] event_code, [4] activity, [7:5] zero
  output logic [7:0]                            m_axis_tdata_o
);

  localparam int unsigned NB = sbed_pkg::NumButtons;

  sbed_pkg::cfg_t cfg;

  sbed_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Per-button and combo counters
  logic [NB-1:0][7:0]             pre_q, pre_d;
  logic [NB-1:0][COUNT_WIDTH-1:0] hold_q, hold_d;
  logic [7:0]                     combo_q, combo_d;

  sbed_pkg::event_e ev;
  logic             act;

  sbed_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .btn_i      (s_axis_tdata_i[NB-1:0]),
    .cfg_i      (cfg),
    .pre_i      (pre_q),
    .hold_i     (hold_q),
    .combo_i    (combo_q),
    .pre_o      (pre_d),
    .hold_o     (hold_d),
    .combo_o    (combo_d),
    .event_o    (ev),
    .activity_o (act)
  );

  logic                   out_valid_q;
  sbed_pkg::event_e       out_event_q;
  logic                   out_act_q;
  logic                   accept;

  // Take a word whenever the output register is free or draining
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q       <= '0;
      hold_q      <= '0;
      combo_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pre_q   <= pre_d;
        hold_q  <= hold_d;
        combo_q <= combo_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_event_q <= ev;
      out_act_q   <= act;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_act_q, out_event_q};

  // Counters move only on an accepted tick
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> ($stable(hold_q) && $stable(pre_q) && $stable(combo_q)))
    else $error("counters changed without an accepted word");

  // Every accepted word leaves a result in the output register
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted word produced no result");

  // Combo counter steps by at most one, or clears
  a_combo_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (combo_q == $past(combo_q) || combo_q == 8'($past(combo_q) + 8'd1)
                || combo_q == 8'd0))
    else $error("combo counter jumped");

  // Event codes stay within the defined set
  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_event_q <= sbed_pkg::EV_MODE_OFF))
    else $error("undefined event code");

endmodule

`default_nettype wire
